/* hw/rtl/bed_pkg.sv */
// Package for the backslash escape decoder: character codes, phase type,
// result bundle type and the hex digit helper.
// No dependencies; used by every module of the block.
`default_nettype none

package bed_pkg;

  localparam int BundleDepth = 4;
  localparam int CountWidth  = 3;
  localparam int IdxWidth    = 2;

  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_R   = 8'h72;
  localparam logic [7:0] CH_N   = 8'h6E;
  localparam logic [7:0] CH_T   = 8'h74;
  localparam logic [7:0] CH_X   = 8'h78;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_BSL   = 2'd1,
    PH_X     = 2'd2,
    PH_DIGIT = 2'd3
  } phase_t;

  // Decoded bytes of one input item, first byte in slot 0.
  typedef struct packed {
    logic [BundleDepth-1:0][7:0] data;
    logic [CountWidth-1:0]       count;
    logic                        last;
  } bundle_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.ok  = 1'b1;
      h.val = c[3:0] + 4'd9;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/bed_decode.sv */
// Escape decoder core: phase and held digit registers plus the decode of one
// input byte into a bundle of up to four output bytes. Depends on bed_pkg.
`default_nettype none

module bed_decode (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic [7:0]       in_byte,
  input  wire logic             is_last,
  output bed_pkg::bundle_t      bundle
);

  bed_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]      held_r, held_nxt;

  bed_pkg::hex_t hex_in;
  bed_pkg::hex_t hex_held;
  logic          plain_hold;   // byte would open a new escape

  assign hex_in     = bed_pkg::hex_value(in_byte);
  assign hex_held   = bed_pkg::hex_value(held_r);
  assign plain_hold = (in_byte == bed_pkg::CH_BSL) && !is_last;

  always_comb begin
    phase_nxt   = phase_r;
    held_nxt    = held_r;
    bundle.data = '0;
    bundle.count = '0;
    bundle.last = is_last;

    unique case (phase_r)
      bed_pkg::PH_IDLE: begin
        bundle.data[0] = in_byte;
        if (plain_hold) begin
          phase_nxt = bed_pkg::PH_BSL;
        end else begin
          phase_nxt    = bed_pkg::PH_IDLE;
          held_nxt     = '0;
          bundle.count = 3'd1;
        end
      end
      bed_pkg::PH_BSL: begin
        if (in_byte == bed_pkg::CH_R || in_byte == bed_pkg::CH_N ||
            in_byte == bed_pkg::CH_T || in_byte == bed_pkg::CH_BSL) begin
          priority if (in_byte == bed_pkg::CH_R) bundle.data[0] = bed_pkg::CH_CR;
          else if (in_byte == bed_pkg::CH_N)     bundle.data[0] = bed_pkg::CH_LF;
          else if (in_byte == bed_pkg::CH_T)     bundle.data[0] = bed_pkg::CH_TAB;
          else                                   bundle.data[0] = bed_pkg::CH_BSL;
          phase_nxt    = bed_pkg::PH_IDLE;
          held_nxt     = '0;
          bundle.count = 3'd1;
        end else if (in_byte == bed_pkg::CH_X && !is_last) begin
          phase_nxt = bed_pkg::PH_X;
        end else begin
          bundle.data[0] = bed_pkg::CH_BSL;
          bundle.data[1] = in_byte;
          if (plain_hold) begin
            phase_nxt    = bed_pkg::PH_BSL;
            bundle.count = 3'd1;
          end else begin
            phase_nxt    = bed_pkg::PH_IDLE;
            held_nxt     = '0;
            bundle.count = 3'd2;
          end
        end
      end
      bed_pkg::PH_X: begin
        if (!is_last && hex_in.ok) begin
          held_nxt  = in_byte;
          phase_nxt = bed_pkg::PH_DIGIT;
        end else begin
          bundle.data[0] = bed_pkg::CH_BSL;
          bundle.data[1] = bed_pkg::CH_X;
          bundle.data[2] = in_byte;
          if (plain_hold) begin
            phase_nxt    = bed_pkg::PH_BSL;
            bundle.count = 3'd2;
          end else begin
            phase_nxt    = bed_pkg::PH_IDLE;
            held_nxt     = '0;
            bundle.count = 3'd3;
          end
        end
      end
      bed_pkg::PH_DIGIT: begin
        if (hex_held.ok && hex_in.ok) begin
          bundle.data[0] = {hex_held.val, hex_in.val};
          phase_nxt      = bed_pkg::PH_IDLE;
          held_nxt       = '0;
          bundle.count   = 3'd1;
        end else begin
          bundle.data[0] = bed_pkg::CH_BSL;
          bundle.data[1] = bed_pkg::CH_X;
          bundle.data[2] = held_r;
          bundle.data[3] = in_byte;
          if (plain_hold) begin
            phase_nxt    = bed_pkg::PH_BSL;
            bundle.count = 3'd3;
          end else begin
            phase_nxt    = bed_pkg::PH_IDLE;
            held_nxt     = '0;
            bundle.count = 3'd4;
          end
        end
      end
      default: begin
        phase_nxt = bed_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bed_pkg::PH_IDLE;
      held_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bed_serializer.sv */
// Result register of the escape decoder: holds one bundle of decoded bytes
// and drains it one byte per handshake. Depends on bed_pkg.
`default_nettype none

module bed_serializer (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire bed_pkg::bundle_t bundle,
  output logic                  can_load,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            out_data,
  output logic                  out_last
);

  bed_pkg::bundle_t                bundle_r;
  logic                            valid_r;
  logic [bed_pkg::IdxWidth-1:0]    idx_r;
  logic [bed_pkg::CountWidth-1:0]  final_idx;
  logic                            at_final;

  assign final_idx = bundle_r.count - 3'd1;
  assign at_final  = (idx_r == final_idx[bed_pkg::IdxWidth-1:0]);
  assign can_load  = !valid_r || (out_ready && at_final);

  assign out_valid = valid_r;
  assign out_data  = bundle_r.data[idx_r];
  assign out_last  = bundle_r.last && at_final;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (valid_r && out_ready) begin
      if (at_final) begin
        valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk) begin
    if (load) begin
      bundle_r <= bundle;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/backslash_escape_decoder_unit.sv */
// Top level of the backslash escape decoder: stream ports, decode core and
// result register. Depends on bed_pkg, bed_decode and bed_serializer.
`default_nettype none

// Decodes C-style backslash escapes in a byte stream. \r \n \t and \\ give
// CR, LF, TAB and backslash; \x followed by two hex digits (0-9, a-f, A-F)
// gives that byte. Any other escape, a bad or missing hex digit, or the end
// of the message inside an escape lets the backslash (and x and held digit)
// pass through literally, and the following byte is decoded afresh. Mark the
// final byte of a message with in_tlast; the final decoded byte of that item
// carries out_tlast, and decoding restarts clean with the next item. Each
// input item produces zero to four output items. Timing: the decode is one
// level of logic from the input port into a bundle register, which then
// drains one byte per cycle while the output is ready. An input item is
// accepted every cycle as long as each item yields at most one byte and the
// output is ready; an item that yields more holds the result register until
// its final byte drains, and the next item waits. Items that yield nothing
// (an escape still pending) do not load it, but like any other item they
// wait while the result register still has more than its final byte to
// drain. The first output byte appears in the cycle after acceptance.
module backslash_escape_decoder_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input channel
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,   // is_last
  // result channel
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] dec_byte
  output logic            out_tlast   // out_last
);

  bed_pkg::bundle_t bundle;
  logic             accept;
  logic             can_load;

  // Accept whenever the result register is free or drains its final byte now.
  assign in_tready = can_load;
  assign accept    = in_tvalid && in_tready;

  bed_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_tdata),
    .is_last (in_tlast),
    .bundle  (bundle)
  );

  // Load only bundles that hold bytes; a pending escape just advances state.
  bed_serializer u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept && (bundle.count != '0)),
    .bundle    (bundle),
    .can_load  (can_load),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

`default_nettype wire

/* dv/backslash_escape_decoder_unit_tb.sv */
// Self-checking testbench for backslash_escape_decoder_unit: random and directed escaped
// messages on the input stream, decoded bytes predicted and checked by a scoreboard class.
// Depends on bed_pkg and the RTL of the block.
module backslash_escape_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } dec_byte_t;

  // Predicts the decoded bytes of every accepted raw byte and checks the
  // decoded stream against them in order.
  class escape_decode_scoreboard;
    bed_pkg::phase_t phase;
    logic [7:0]      held;
    dec_byte_t       decoded_q[$];
    int unsigned     n_fail;

    function new();
      phase  = bed_pkg::PH_IDLE;
      held   = 8'h00;
      n_fail = 0;
    endfunction

    function int digit_of(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      return -1;
    endfunction

    function void push_decoded(logic [7:0] b, logic l);
      dec_byte_t d;
      d.data = b;
      d.last = l;
      decoded_q.push_back(d);
    endfunction

    // Ordinary byte with no escape pending.
    function void plain_byte(logic [7:0] b, logic l);
      if (b == bed_pkg::CH_BSL && !l) begin
        phase = bed_pkg::PH_BSL;
      end else begin
        phase = bed_pkg::PH_IDLE;
        held  = 8'h00;
        push_decoded(b, l);
      end
    endfunction

    function void note_raw_byte(logic [7:0] b, logic l);
      int hi;
      int lo;
      case (phase)
        bed_pkg::PH_IDLE: begin
          plain_byte(b, l);
        end
        bed_pkg::PH_BSL: begin
          if (b == bed_pkg::CH_R) begin
            phase = bed_pkg::PH_IDLE;
            push_decoded(bed_pkg::CH_CR, l);
          end else if (b == bed_pkg::CH_N) begin
            phase = bed_pkg::PH_IDLE;
            push_decoded(bed_pkg::CH_LF, l);
          end else if (b == bed_pkg::CH_T) begin
            phase = bed_pkg::PH_IDLE;
            push_decoded(bed_pkg::CH_TAB, l);
          end else if (b == bed_pkg::CH_BSL) begin
            phase = bed_pkg::PH_IDLE;
            push_decoded(bed_pkg::CH_BSL, l);
          end else if (b == bed_pkg::CH_X && !l) begin
            phase = bed_pkg::PH_X;
          end else begin
            push_decoded(bed_pkg::CH_BSL, 1'b0);
            plain_byte(b, l);
          end
        end
        bed_pkg::PH_X: begin
          if (!l && digit_of(b) >= 0) begin
            held  = b;
            phase = bed_pkg::PH_DIGIT;
          end else begin
            push_decoded(bed_pkg::CH_BSL, 1'b0);
            push_decoded(bed_pkg::CH_X, 1'b0);
            plain_byte(b, l);
          end
        end
        default: begin
          hi = digit_of(held);
          lo = digit_of(b);
          if (hi >= 0 && lo >= 0) begin
            phase = bed_pkg::PH_IDLE;
            held  = 8'h00;
            push_decoded(8'(hi * 16 + lo), l);
          end else begin
            push_decoded(bed_pkg::CH_BSL, 1'b0);
            push_decoded(bed_pkg::CH_X, 1'b0);
            push_decoded(held, 1'b0);
            plain_byte(b, l);
          end
        end
      endcase
    endfunction

    function void check_decoded_byte(logic [7:0] b, logic l);
      dec_byte_t exp_b;
      if (decoded_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10)
          $display("unexpected decoded byte %02h last %0b, nothing pending", b, l);
        return;
      end
      exp_b = decoded_q.pop_front();
      if (exp_b.data !== b || exp_b.last !== l) begin
        n_fail++;
        if (n_fail <= 10)
          $display("mismatch: got byte %02h last %0b, expected byte %02h last %0b",
                   b, l, exp_b.data, exp_b.last);
      end
    endfunction

    function int outstanding();
      return decoded_q.size();
    endfunction
  endclass

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // [7:0] in_byte
  logic       in_tlast   = 1'b0;   // is_last
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [7:0] dec_byte
  logic       out_tlast;           // out_last

  escape_decode_scoreboard sb;
  bit quiet     = 1'b0;  // suppress random idling on both sides
  int hold_left = 0;     // cycles the receiver still has to hold off
  int items_sent = 0;

  backslash_escape_decoder_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: check each accepted decoded byte, then pick ready for the next
  // cycle. A pending hold-off wins over random idling.
  initial begin
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        sb.check_decoded_byte(out_tdata, out_tlast);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(99) < 6) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offer one raw byte, with an occasional random gap first, and hold it
  // until the block takes it. Valid stays high afterwards; the caller
  // lowers it when the stream pauses.
  task automatic send_item(input logic [7:0] b, input logic l);
    while (!quiet && $urandom_range(99) < 6) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    sb.note_raw_byte(b, l);
    items_sent++;
  endtask

  function automatic logic [7:0] pick_hex_char();
    int v;
    v = $urandom_range(15);
    if (v < 10) return 8'(8'h30 + v);
    if ($urandom_range(1)) return 8'(8'h61 + v - 10);
    return 8'(8'h41 + v - 10);
  endfunction

  function automatic logic [7:0] pick_escape_char();
    case ($urandom_range(3))
      0:       return bed_pkg::CH_R;
      1:       return bed_pkg::CH_N;
      2:       return bed_pkg::CH_T;
      default: return bed_pkg::CH_BSL;
    endcase
  endfunction

  // Build one message from random tokens: mostly plain bytes and well-formed
  // escapes, some broken escapes. A message cut inside an escape is fine.
  task automatic send_random_message();
    logic [7:0] msg[$];
    int         n_tok;
    int         kind;
    n_tok = $urandom_range(1, 6);
    for (int t = 0; t < n_tok; t++) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        msg.push_back(8'($urandom_range(255)));
      end else if (kind < 60) begin
        msg.push_back(bed_pkg::CH_BSL);
        msg.push_back(pick_escape_char());
      end else if (kind < 80) begin
        msg.push_back(bed_pkg::CH_BSL);
        msg.push_back(bed_pkg::CH_X);
        msg.push_back(pick_hex_char());
        msg.push_back(pick_hex_char());
      end else if (kind < 90) begin
        msg.push_back(bed_pkg::CH_BSL);
        msg.push_back(bed_pkg::CH_X);
        if ($urandom_range(1)) msg.push_back(pick_hex_char());
        msg.push_back(8'($urandom_range(255)));
      end else begin
        msg.push_back(bed_pkg::CH_BSL);
        msg.push_back(8'($urandom_range(255)));
      end
    end
    for (int i = 0; i < msg.size(); i++) begin
      send_item(msg[i], i == msg.size() - 1);
    end
  endtask

  task automatic wait_drained();
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: byte extremes and each escape form.
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(bed_pkg::CH_BSL, 1'b0); send_item(bed_pkg::CH_R, 1'b0);
    send_item(bed_pkg::CH_BSL, 1'b0); send_item(bed_pkg::CH_N, 1'b0);
    send_item(bed_pkg::CH_BSL, 1'b0); send_item(bed_pkg::CH_T, 1'b0);
    send_item(bed_pkg::CH_BSL, 1'b0); send_item(bed_pkg::CH_BSL, 1'b0);
    // hex escape, mixed case, ending the message
    send_item(bed_pkg::CH_BSL, 1'b0); send_item(bed_pkg::CH_X, 1'b0);
    send_item(8'h66, 1'b0);  send_item(8'h46, 1'b1);
    // unknown escape
    send_item(bed_pkg::CH_BSL, 1'b0); send_item(8'h71, 1'b0);
    // backslash as the final byte
    send_item(bed_pkg::CH_BSL, 1'b1);
    // message ends on the first digit after the x
    send_item(bed_pkg::CH_BSL, 1'b0); send_item(bed_pkg::CH_X, 1'b0);
    send_item(8'h37, 1'b1);
    // a sign is never a hex digit
    send_item(bed_pkg::CH_BSL, 1'b0); send_item(bed_pkg::CH_X, 1'b0);
    send_item(8'h2B, 1'b0);
    // bad second digit is a backslash that starts a new escape
    send_item(bed_pkg::CH_BSL, 1'b0); send_item(bed_pkg::CH_X, 1'b0);
    send_item(8'h34, 1'b0);
    send_item(bed_pkg::CH_BSL, 1'b0); send_item(bed_pkg::CH_N, 1'b1);

    // Random messages with idling on both sides.
    while (items_sent < 90) send_random_message();

    // Back-to-back stretch, no idling at all.
    quiet = 1'b1;
    while (items_sent < 140) send_random_message();
    quiet = 1'b0;

    // Long receiver hold-off while the sender keeps offering.
    hold_left = 200;
    while (items_sent < 170) send_random_message();

    // Pause the sender until the block has drained, then resume.
    in_tvalid <= 1'b0;
    wait_drained();
    while (items_sent < 200) send_random_message();
    in_tvalid <= 1'b0;

    // Drain, then give stray bytes a chance to show up.
    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.n_fail == 0 && sb.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
